### sv/cbc_pkg.sv
// Shared types and codes for the cartridge bank controller.
// No dependencies; used by every module of the block.
package cbc_pkg;

  // Access kinds (tuser on the request side)
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Result targets (tuser on the result side)
  localparam logic [1:0] TGT_INTERNAL = 2'd0;
  localparam logic [1:0] TGT_ROM      = 2'd1;
  localparam logic [1:0] TGT_RAM      = 2'd2;
  localparam logic [1:0] TGT_DROP     = 2'd3;

  // Controller kinds that react to control writes
  localparam logic [2:0] CTRL_NONE  = 3'd0;
  localparam logic [2:0] CTRL_ONE   = 3'd1;
  localparam logic [2:0] CTRL_THREE = 3'd3;

  // Clock select states (type three)
  localparam logic [1:0] CS_RAM   = 2'd0;
  localparam logic [1:0] CS_CLOCK = 2'd1;
  localparam logic [1:0] CS_ARMED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_KIND      = 2'd0;
  localparam logic [1:0] CFG_ROM_COUNT = 2'd1;
  localparam logic [1:0] CFG_RAM_COUNT = 2'd2;
  localparam logic [1:0] CFG_RAM_SMALL = 2'd3;

  // Control write regions, address bits 14:13 below 0x8000
  localparam logic [1:0] REG_RAM_EN   = 2'd0;
  localparam logic [1:0] REG_BANK_LO  = 2'd1;
  localparam logic [1:0] REG_BANK_HI  = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [7:0] CLK_SEL_LO   = 8'h08;
  localparam logic [7:0] CLK_SEL_HI   = 8'h0C;

  localparam int REQ_DATA_W = 24;
  localparam int RES_DATA_W = 24;

  typedef struct packed {
    logic [2:0] controller_kind;
    logic [7:0] rom_banks;
    logic [3:0] ram_bank_count;
    logic       ram_small;
  } cfg_t;

  typedef struct packed {
    logic [6:0] rom_bank_index;
    logic [1:0] ram_bank_index;
    logic       ram_enabled;
    logic       banking_mode;
    logic [1:0] clock_select;
  } ctrl_state_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [6:0]  bank;
    logic [15:0] local_address;
  } res_t;

endpackage

### sv/cbc_state.sv
// Banking state of the controller, updated by control writes below 0x8000.
// Depends on cbc_pkg.
module cbc_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  cbc_pkg::req_t        req,
  input  cbc_pkg::cfg_t        cfg,
  output cbc_pkg::ctrl_state_t st
);

  cbc_pkg::ctrl_state_t st_next;

  always_comb begin
    logic [7:0] d;
    logic [6:0] rom;
    d = req.write_data;
    rom = st.rom_bank_index;
    st_next = st;
    if (update && req.kind == cbc_pkg::KIND_WRITE && !req.address[15] &&
        (cfg.controller_kind == cbc_pkg::CTRL_ONE ||
         cfg.controller_kind == cbc_pkg::CTRL_THREE)) begin
      if (req.address[14:13] == cbc_pkg::REG_RAM_EN) begin
        st_next.ram_enabled = (d[3:0] == cbc_pkg::RAM_EN_KEY);
      end else if (cfg.controller_kind == cbc_pkg::CTRL_ONE) begin
        case (req.address[14:13])
          cbc_pkg::REG_BANK_LO: begin
            rom = {rom[6:5], d[4:0]};
            if (rom[4:0] == 5'd0) rom[0] = 1'b1;
            st_next.rom_bank_index = rom;
          end
          cbc_pkg::REG_BANK_HI: begin
            if (!st.banking_mode) begin
              rom = {d[1:0], rom[4:0]};
              if (rom[4:0] == 5'd0) rom[0] = 1'b1;
              st_next.rom_bank_index = rom;
            end else begin
              st_next.ram_bank_index = d[1:0];
            end
          end
          default: st_next.banking_mode = d[0];
        endcase
      end else begin
        case (req.address[14:13])
          cbc_pkg::REG_BANK_LO: st_next.rom_bank_index = d[6:0];
          cbc_pkg::REG_BANK_HI: begin
            if (d >= cbc_pkg::CLK_SEL_LO && d <= cbc_pkg::CLK_SEL_HI) begin
              st_next.clock_select = cbc_pkg::CS_CLOCK;
            end else begin
              if (d[7:2] == 6'd0) st_next.ram_bank_index = d[1:0];
              st_next.clock_select = cbc_pkg::CS_RAM;
            end
          end
          default: begin
            // latch sequence: 0 arms, then 1 returns to clock selected
            if (st.clock_select == cbc_pkg::CS_CLOCK && d == 8'd0)
              st_next.clock_select = cbc_pkg::CS_ARMED;
            else if (st.clock_select == cbc_pkg::CS_ARMED && d == 8'd1)
              st_next.clock_select = cbc_pkg::CS_CLOCK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

### sv/cbc_map.sv
// Address decode: maps one access onto internal memory, a ROM bank,
// a RAM bank or a dropped write. Pure logic; depends on cbc_pkg.
module cbc_map (
  input  cbc_pkg::req_t        req,
  input  cbc_pkg::cfg_t        cfg,
  input  cbc_pkg::ctrl_state_t st,
  output cbc_pkg::res_t        res
);

  logic is_write;
  logic ram_window;
  logic ram_ok;
  logic rom_ok;

  assign is_write   = (req.kind == cbc_pkg::KIND_WRITE);
  assign ram_window = (req.address[15:13] == 3'b101);
  // 2 KiB parts only answer below 0xA800
  assign ram_ok = st.ram_enabled && st.clock_select == cbc_pkg::CS_RAM &&
                  cfg.ram_bank_count != 4'd0 &&
                  (req.address[12:11] == 2'b00 || !cfg.ram_small) &&
                  ({2'b00, st.ram_bank_index} < cfg.ram_bank_count);
  assign rom_ok = !is_write && req.address[15:14] == 2'b01 &&
                  cfg.controller_kind != cbc_pkg::CTRL_NONE &&
                  ({1'b0, st.rom_bank_index} < cfg.rom_banks);

  always_comb begin
    res.target        = cbc_pkg::TGT_INTERNAL;
    res.bank          = 7'd0;
    res.local_address = req.address;
    if (is_write && !req.address[15]) begin
      res.target = cbc_pkg::TGT_DROP;
    end else if (ram_window) begin
      if (ram_ok) begin
        res.target        = cbc_pkg::TGT_RAM;
        res.bank          = {5'd0, st.ram_bank_index};
        res.local_address = {3'd0, req.address[12:0]};
      end else if (is_write) begin
        res.target = cbc_pkg::TGT_DROP;
      end
    end else if (rom_ok) begin
      res.target        = cbc_pkg::TGT_ROM;
      // bank zero reads as bank one
      res.bank          = (st.rom_bank_index == 7'd0) ? 7'd1 : st.rom_bank_index;
      res.local_address = {2'd0, req.address[13:0]};
    end
  end

endmodule

### sv/cartridge_bank_controller_top.sv
// Top level of the cartridge bank controller: request register, decode,
// result register and configuration registers. Depends on cbc_pkg,
// cbc_state and cbc_map.
//
// Usage:
//   Requests enter on s_* (tuser = access kind, tdata = address and data).
//   Each request yields exactly one result on m_* (tuser = target,
//   tdata = bank and local address), in order.
//   A request passes the request register, then the result register, on its
//   way to m_tvalid. Throughput: one request per cycle while the result side
//   does not stall; the decode and the banking state update both sit in the
//   single logic stage between the two registers, so each request sees the
//   state left by the one before it.
//   Stalls: while m_tready is low the result holds, the request register
//   still takes one more request if it is empty, then s_tready drops until
//   the result drains.
//   Reset (rst, synchronous) empties both registers and clears the banking
//   state; configuration returns to kind none, two ROM banks, no RAM,
//   full-size RAM window.
//   Configuration: cfg_ready is always high; write only while idle.
module cartridge_bank_controller_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  input  logic        s_tuser,   // [0] kind
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] bank, [22:7] local_address, [23] zero
  output logic [1:0]  m_tuser,   // [1:0] target
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cbc_pkg::cfg_t        cfg;
  cbc_pkg::ctrl_state_t st;
  cbc_pkg::req_t        req;
  cbc_pkg::res_t        res;
  cbc_pkg::res_t        res_q;

  logic req_valid;
  logic res_ready;
  logic advance;

  // result register can load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;
  assign advance   = req_valid && res_ready;
  assign s_tready  = !req_valid || res_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.controller_kind <= cbc_pkg::CTRL_NONE;
      cfg.rom_banks       <= 8'd2;
      cfg.ram_bank_count  <= 4'd0;
      cfg.ram_small       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbc_pkg::CFG_KIND:      cfg.controller_kind <= cfg_data[2:0];
        cbc_pkg::CFG_ROM_COUNT: cfg.rom_banks       <= cfg_data;
        cbc_pkg::CFG_RAM_COUNT: cfg.ram_bank_count  <= cfg_data[3:0];
        cbc_pkg::CFG_RAM_SMALL: cfg.ram_small       <= cfg_data[0];
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.kind       <= s_tuser;
      req.address    <= s_tdata[15:0];
      req.write_data <= s_tdata[23:16];
    end
  end

  // banking state advances only when the request moves to the result stage
  cbc_state u_state (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .req    (req),
    .cfg    (cfg),
    .st     (st)
  );

  cbc_map u_map (
    .req (req),
    .cfg (cfg),
    .st  (st),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.target;
  assign m_tdata = {1'b0, res_q.local_address, res_q.bank};

endmodule

### sv/cbc_checker.sv
// Port-level checks for the cartridge bank controller, bound to the top.
// Depends on cbc_pkg and cartridge_bank_controller_top.
module cbc_props (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // no result may appear right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // only ROM and RAM results carry a bank number
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == cbc_pkg::TGT_INTERNAL || m_tuser == cbc_pkg::TGT_DROP)
    |-> m_tdata[6:0] == 7'd0)
    else $error("bank set on non-banked target");

  // ROM results: bank never zero, offset within 16 KiB
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cbc_pkg::TGT_ROM
    |-> m_tdata[6:0] != 7'd0 && m_tdata[22:21] == 2'b00)
    else $error("bad ROM bank or offset");

  // RAM results: bank below four, offset within 8 KiB
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cbc_pkg::TGT_RAM
    |-> m_tdata[6:2] == 5'd0 && m_tdata[22:20] == 3'b000)
    else $error("bad RAM bank or offset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind cartridge_bank_controller_top cbc_props u_cbc_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### sim/cbc_checker.sv
// Scoreboard for the cartridge bank controller: follows the configuration and
// request channels, predicts where each access maps and checks the result stream.
// Depends on cbc_pkg.
module cbc_checker
  import cbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          outstanding,
  output int          checked
);

  localparam logic [15:0] ROM_WIN_LO   = 16'h4000;
  localparam logic [15:0] CTRL_WIN_HI  = 16'h8000;
  localparam logic [15:0] RAM_WIN_LO   = 16'hA000;
  localparam logic [15:0] RAM_SMALL_HI = 16'hA800;
  localparam logic [15:0] RAM_WIN_HI   = 16'hC000;
  localparam logic [7:0]  RAM_SEL_MAX  = 8'd3;
  localparam int          REPORT_MAX   = 10;

  cfg_t        mapper_cfg;
  ctrl_state_t bank_regs;
  res_t        mapped_q[$];

  // Control write below 0x8000; only type one and type three react.
  task automatic program_bank_regs(input logic [15:0] addr, input logic [7:0] data);
    logic fix_zero;
    fix_zero = 1'b0;
    if (mapper_cfg.controller_kind != CTRL_ONE && mapper_cfg.controller_kind != CTRL_THREE)
      return;
    if (addr[14:13] == REG_RAM_EN) begin
      bank_regs.ram_enabled = (data[3:0] == RAM_EN_KEY);
    end else if (mapper_cfg.controller_kind == CTRL_ONE) begin
      case (addr[14:13])
        REG_BANK_LO: begin
          bank_regs.rom_bank_index[4:0] = data[4:0];
          fix_zero = 1'b1;
        end
        REG_BANK_HI: begin
          if (!bank_regs.banking_mode) begin
            bank_regs.rom_bank_index[6:5] = data[1:0];
            fix_zero = 1'b1;
          end else begin
            bank_regs.ram_bank_index = data[1:0];
          end
        end
        default: bank_regs.banking_mode = data[0];
      endcase
      // low five bits of zero select bank one
      if (fix_zero && bank_regs.rom_bank_index[4:0] == 5'd0)
        bank_regs.rom_bank_index[0] = 1'b1;
    end else begin
      case (addr[14:13])
        REG_BANK_LO: bank_regs.rom_bank_index = data[6:0];
        REG_BANK_HI: begin
          if (data >= CLK_SEL_LO && data <= CLK_SEL_HI) begin
            bank_regs.clock_select = CS_CLOCK;
          end else begin
            if (data <= RAM_SEL_MAX)
              bank_regs.ram_bank_index = data[1:0];
            bank_regs.clock_select = CS_RAM;
          end
        end
        default: begin
          if (bank_regs.clock_select == CS_CLOCK && data == 8'd0)
            bank_regs.clock_select = CS_ARMED;
          else if (bank_regs.clock_select == CS_ARMED && data == 8'd1)
            bank_regs.clock_select = CS_CLOCK;
        end
      endcase
    end
  endtask

  task automatic map_access(input req_t req, output res_t res);
    logic ram_ok;
    res.target        = TGT_INTERNAL;
    res.bank          = '0;
    res.local_address = req.address;
    if (req.kind == KIND_WRITE && req.address < CTRL_WIN_HI) begin
      program_bank_regs(req.address, req.write_data);
      res.target = TGT_DROP;
    end else if (req.address >= RAM_WIN_LO && req.address < RAM_WIN_HI) begin
      ram_ok = bank_regs.ram_enabled && bank_regs.clock_select == CS_RAM &&
               mapper_cfg.ram_bank_count != 4'd0 &&
               (req.address < RAM_SMALL_HI || !mapper_cfg.ram_small) &&
               {2'b00, bank_regs.ram_bank_index} < mapper_cfg.ram_bank_count;
      if (ram_ok) begin
        res.target        = TGT_RAM;
        res.bank          = {5'd0, bank_regs.ram_bank_index};
        res.local_address = req.address - RAM_WIN_LO;
      end else if (req.kind == KIND_WRITE) begin
        res.target = TGT_DROP;
      end
    end else if (req.kind == KIND_READ && req.address >= ROM_WIN_LO &&
                 req.address < CTRL_WIN_HI && mapper_cfg.controller_kind != CTRL_NONE &&
                 {1'b0, bank_regs.rom_bank_index} < mapper_cfg.rom_banks) begin
      res.target        = TGT_ROM;
      res.bank          = (bank_regs.rom_bank_index == 7'd0) ? 7'd1 : bank_regs.rom_bank_index;
      res.local_address = req.address - ROM_WIN_LO;
    end
  endtask

  task automatic flag_result(input string why, input res_t want, input res_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%0t: %s: expected target %0d bank %0d addr %h, got target %0d bank %0d addr %h",
               $time, why, want.target, want.bank, want.local_address,
               got.target, got.bank, got.local_address);
  endtask

  always @(posedge clk) begin : track
    req_t req;
    res_t got;
    res_t want;
    if (rst) begin
      mapper_cfg.controller_kind = CTRL_NONE;
      mapper_cfg.rom_banks       = 8'd2;
      mapper_cfg.ram_bank_count  = 4'd0;
      mapper_cfg.ram_small       = 1'b0;
      bank_regs = '0;
      mapped_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        got.target        = m_tuser;
        got.bank          = m_tdata[6:0];
        got.local_address = m_tdata[22:7];
        checked++;
        if (mapped_q.size() == 0) begin
          flag_result("unexpected result", '0, got);
        end else begin
          want = mapped_q.pop_front();
          if (got.target !== want.target || got.bank !== want.bank ||
              got.local_address !== want.local_address)
            flag_result("mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KIND:      mapper_cfg.controller_kind = cfg_data[2:0];
          CFG_ROM_COUNT: mapper_cfg.rom_banks       = cfg_data;
          CFG_RAM_COUNT: mapper_cfg.ram_bank_count  = cfg_data[3:0];
          default:       mapper_cfg.ram_small       = cfg_data[0];
        endcase
      end
      if (s_tvalid && s_tready) begin
        req.kind       = s_tuser;
        req.address    = s_tdata[15:0];
        req.write_data = s_tdata[23:16];
        map_access(req, want);
        mapped_q.push_back(want);
      end
    end
    outstanding = mapped_q.size();
  end

endmodule

### sim/tb_cartridge_bank_controller_top.sv
// Testbench top for the cartridge bank controller: drives requests, config writes
// and result backpressure; cbc_checker does the prediction and comparison.
// Depends on cbc_pkg, cbc_checker and cartridge_bank_controller_top.
module tb_cartridge_bank_controller_top;
  import cbc_pkg::*;

  // Controller kinds that bank ROM reads but ignore control writes
  localparam logic [2:0] CTRL_TWO    = 3'd2;
  localparam logic [2:0] CTRL_FOUR   = 3'd4;
  localparam logic [2:0] CTRL_FIVE   = 3'd5;
  localparam logic [2:0] CTRL_UNUSED = 3'd7;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int LONG_HOLD   = 40;  // receiver hold-off, in cycles
  localparam int DRAIN_TAIL  = 4;   // two-stage pipe plus margin

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic        s_tuser   = KIND_READ;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_KIND;
  logic [7:0]  cfg_data  = '0;

  int errors;
  int outstanding;
  int checked;
  int burst_left    = 0;
  int sent          = 0;
  int settings      = 0;
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  cartridge_bank_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cbc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side backpressure. Runs a stall pattern (an 8-bit ready mask,
  // replayed cyclically) that is picked anew at random intervals; all-ones
  // gives stretches with no stall. On request from the stimulus it instead
  // holds m_tready low for the LONG_HOLD hold-off, counted here, so the pipe
  // fills and s_tready has to drop while the sender keeps offering.
  initial begin : receiver
    logic [7:0] ready_mask;
    int         pattern_left;
    int         phase;
    ready_mask   = 8'hFF;
    pattern_left = 0;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0:       ready_mask = 8'hFF;
            1:       ready_mask = 8'b1010_1010;
            2:       ready_mask = 8'h11;
            default: ready_mask = 8'($urandom_range(1, 255));
          endcase
        end
        pattern_left--;
        m_tready <= ready_mask[phase % 8];
        phase++;
      end
    end
  end

  // One request. Called right after a falling edge, returns right after the
  // falling edge that follows acceptance with s_tvalid still high, so that
  // back-to-back requests keep valid asserted. Bursts of random length are
  // separated by random gaps.
  task automatic send_access(input logic kind, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Sender pause: drop valid and wait for every predicted result, then the
  // DRAIN_TAIL margin so the pipe is empty before any config write.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // Writes all four config registers back to back; call only when idle.
  task automatic apply_settings(input logic [7:0] kind_word, input logic [7:0] rom_word,
                                input logic [7:0] ram_word, input logic [7:0] small_word);
    logic [7:0] vals [4];
    vals[CFG_KIND]      = kind_word;
    vals[CFG_ROM_COUNT] = rom_word;
    vals[CFG_RAM_COUNT] = ram_word;
    vals[CFG_RAM_SMALL] = small_word;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Random request mix: mostly control writes with meaningful data, ROM reads
  // and external RAM traffic, plus a share of accesses anywhere.
  task automatic pick_access(output logic kind, output logic [15:0] addr,
                             output logic [7:0] data);
    int sel;
    sel  = $urandom_range(0, 99);
    kind = 1'($urandom);
    data = 8'($urandom);
    addr = 16'($urandom);
    if (sel < 40) begin
      kind = KIND_WRITE;
      addr = 16'($urandom_range(16'h0000, 16'h7FFF));
      case ($urandom_range(0, 4))
        0:       data = {data[7:4], RAM_EN_KEY};
        1:       data = 8'($urandom_range(CLK_SEL_LO, CLK_SEL_HI));
        2:       data = 8'($urandom_range(0, 3));  // bank select, latch steps
        default: ;
      endcase
    end else if (sel < 70) begin
      kind = KIND_READ;
      addr = 16'($urandom_range(16'h4000, 16'h7FFF));
    end else if (sel < 95) begin
      addr = 16'($urandom_range(16'hA000, 16'hBFFF));
    end
  endtask

  initial begin : stimulus
    logic       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [2:0]  ctrl;
    logic [7:0]  rom_banks;
    logic [3:0]  ram_banks;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: no controller, so control writes are dropped without
    // effect and the ROM window reads as internal memory.
    send_access(KIND_WRITE, 16'h0000, 8'h0A);
    send_access(KIND_READ,  16'h4000, 8'h00);
    send_access(KIND_READ,  16'hA000, 8'h00);
    send_access(KIND_WRITE, 16'hFFFF, 8'hFF);
    send_access(KIND_READ,  16'h0000, 8'h00);
    quiesce();

    // Type one, full ROM count, small RAM
    apply_settings({5'd0, CTRL_ONE}, 8'd255, 8'd4, 8'd1);
    send_access(KIND_WRITE, 16'h1FFF, 8'h1A);  // enable by low nibble only
    send_access(KIND_READ,  16'h4000, 8'h00);  // index zero reads as bank one
    send_access(KIND_WRITE, 16'h2000, 8'hE0);  // zero low part becomes one
    send_access(KIND_WRITE, 16'h5FFF, 8'h03);  // upper bits replace, ROM mode
    send_access(KIND_READ,  16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h6000, 8'h01);  // RAM banking mode
    send_access(KIND_WRITE, 16'h4000, 8'h02);  // RAM bank two
    send_access(KIND_WRITE, 16'hA7FF, 8'h55);
    send_access(KIND_READ,  16'hA800, 8'h00);  // beyond the 2 KiB window
    send_access(KIND_WRITE, 16'hBFFF, 8'h00);  // dropped write
    quiesce();

    // Type three: clock select, latch sequence, bank index equal to the RAM count
    apply_settings({5'd0, CTRL_THREE}, 8'd128, 8'd3, 8'd0);
    send_access(KIND_WRITE, 16'h3FFF, 8'hFF);
    send_access(KIND_READ,  16'h7FFF, 8'h00);
    send_access(KIND_WRITE, 16'h4000, 8'h08);
    send_access(KIND_READ,  16'hA000, 8'h00);
    send_access(KIND_WRITE, 16'h6000, 8'h00);
    send_access(KIND_WRITE, 16'h7FFF, 8'h01);
    send_access(KIND_WRITE, 16'h4000, 8'h03);
    send_access(KIND_READ,  16'hBFFF, 8'h00);
    quiesce();

    // Random phases, each under its own settings; the first three hit the
    // count extremes. Unused register bits are randomized as well.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       ctrl = CTRL_ONE;
        1:       ctrl = CTRL_THREE;
        2:       ctrl = CTRL_NONE;
        3:       ctrl = CTRL_TWO;
        4:       ctrl = CTRL_FOUR;
        5:       ctrl = CTRL_FIVE;
        6:       ctrl = CTRL_UNUSED;
        default: ctrl = ($urandom_range(0, 1) != 0) ? CTRL_ONE : CTRL_THREE;
      endcase
      case (p)
        0: begin
          rom_banks = 8'd255;
          ram_banks = 4'd15;
        end
        1: begin
          rom_banks = 8'd0;
          ram_banks = 4'd0;
        end
        2: begin
          rom_banks = 8'd1;
          ram_banks = 4'd1;
        end
        default: begin
          rom_banks = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8))
                                                   : 8'($urandom);
          ram_banks = 4'($urandom);
        end
      endcase
      apply_settings({5'($urandom), ctrl}, rom_banks, {4'($urandom), ram_banks},
                     {7'($urandom), 1'(p)});

      // long receiver hold-off while requests keep coming
      if (p == 3 || p == 8)
        long_hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_access(kind, addr, data);
        send_access(kind, addr, data);
      end
      quiesce();
    end

    $display("Checked %0d results for %0d requests under %0d controller settings",
             checked, sent, settings);
    $display("(directed corners, then random mixes with bursts and backpressure)");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
sv/cbc_pkg.sv
sv/cbc_state.sv
sv/cbc_map.sv
sv/cartridge_bank_controller_top.sv
sv/cbc_checker.sv
sim/cbc_checker.sv
sim/tb_cartridge_bank_controller_top.sv
